@@ rtl/core/tbsm_pkg.sv @@
// Package for the two-bit segment map: sizes, codes, types and control structs.
`timescale 1ns / 1ps
package tbsm_pkg;

  // Map geometry
  localparam int unsigned MAP_WORDS       = 2048;
  localparam int unsigned BLOCKS_PER_WORD = 32;  // power of two
  localparam int unsigned MAX_COUNT       = 63;

  // Derived widths
  localparam int unsigned BLK_W   = 16;
  localparam int unsigned USED_W  = BLK_W + 1;
  localparam int unsigned CNT_W   = $clog2(MAX_COUNT + 1);
  localparam int unsigned ENT_W   = $clog2(BLOCKS_PER_WORD);
  localparam int unsigned WORD_AW = $clog2(MAP_WORDS);
  localparam int unsigned MAP_DW  = 2 * BLOCKS_PER_WORD;
  localparam int unsigned KIND_W  = 2;

  // Configuration register
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned REG_IDX_W = 1;
  localparam int unsigned APB_AW    = REG_IDX_W + 2;
  localparam logic [CFG_W-1:0]     CFG_RESET     = CFG_W'(2048);
  localparam logic [REG_IDX_W-1:0] REG_MAP_WORDS = '0;

  // Per-block map codes
  typedef enum logic [1:0] {
    BLK_EMPTY = 2'd0,
    BLK_START = 2'd1,
    BLK_IN    = 2'd2,
    BLK_ERR   = 2'd3
  } blk_st_e;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    RES_OVERLAP = 2'd0,
    RES_DONE    = 2'd1,
    RES_ERROR   = 2'd2
  } res_kind_e;

  // Cursor and end-block updates
  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_B0,
    CUR_INC,
    CUR_DEC
  } cur_op_e;

  typedef enum logic [1:0] {
    END_HOLD,
    END_INS,
    END_CUR
  } end_op_e;

  // Controller states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_FETCH,
    S_FILL,
    S_INS_FIRST,
    S_SRCH,
    S_INS_MARK,
    S_INS_REST,
    S_RM_FIRST,
    S_RM_WALK,
    S_DONE,
    S_ERR
  } ctrl_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic      clr_en;
    logic      req_load;
    cur_op_e   cur_op;
    logic      wr_en;
    blk_st_e   wr_st;
    logic      fill;
    end_op_e   end_op;
    logic      emit_en;
    res_kind_e emit_kind;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic    clr_last;
    logic    hit;
    blk_st_e ent_st;
    logic    range_err;
    logic    is_remove;
    logic    cur_zero;
    logic    cur_at_end;
    logic    cur_last_used;
    logic    out_free;
  } sts_t;

endpackage

@@ rtl/core/tbsm_req_if.sv @@
// Request channel: valid/ready handshake carrying one segment request.
`timescale 1ns / 1ps
interface tbsm_req_if;
  import tbsm_pkg::*;

  logic             valid;
  logic             ready;
  logic             req_type;
  logic [BLK_W-1:0] start_block;
  logic [CNT_W-1:0] block_count;

  modport source (output valid, output req_type, output start_block, output block_count,
                  input ready);
  modport sink (input valid, input req_type, input start_block, input block_count,
                output ready);
endinterface

@@ rtl/core/tbsm_res_if.sv @@
// Result channel: valid/ready handshake carrying one result item.
`timescale 1ns / 1ps
interface tbsm_res_if;
  import tbsm_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] result_kind;
  logic [BLK_W-1:0]  overlap_start;
  logic [BLK_W-1:0]  end_block;
  logic              last;

  modport source (output valid, output result_kind, output overlap_start,
                  output end_block, output last, input ready);
  modport sink (input valid, input result_kind, input overlap_start,
                input end_block, input last, output ready);
endinterface

@@ rtl/core/tbsm_datapath.sv @@
// Datapath: map memory, word buffer, cursor, request registers and result register.
`timescale 1ns / 1ps
module tbsm_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tbsm_pkg::cmd_t            cmd_i,
  output tbsm_pkg::sts_t            sts_o,
  input  logic [tbsm_pkg::USED_W-1:0] used_i,
  input  logic                      req_type_i,
  input  logic [tbsm_pkg::BLK_W-1:0] start_block_i,
  input  logic [tbsm_pkg::CNT_W-1:0] block_count_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [tbsm_pkg::KIND_W-1:0] result_kind_o,
  output logic [tbsm_pkg::BLK_W-1:0] overlap_start_o,
  output logic [tbsm_pkg::BLK_W-1:0] end_block_o,
  output logic                      last_o
);
  import tbsm_pkg::*;

  // Map memory, one word of packed 2-bit entries per address
  logic [MAP_DW-1:0]  mem [MAP_WORDS];
  logic [MAP_DW-1:0]  rdata_q;
  logic               mem_we;
  logic [WORD_AW-1:0] mem_waddr;
  logic [MAP_DW-1:0]  mem_wdata;

  // Clearing pass
  logic [WORD_AW-1:0] clr_cnt_q, clr_cnt_d;

  // Request
  logic               req_rm_q;
  logic [BLK_W-1:0]   b0_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [CNT_W-1:0]   cnt_eff;

  // Cursor and end block
  logic [BLK_W-1:0]   cur_q, cur_d;
  logic [BLK_W-1:0]   end_q, end_d;
  logic [WORD_AW-1:0] cur_word;
  logic [ENT_W:0]     ent_bit;

  // Word buffer, written through to the memory on every change
  logic [MAP_DW-1:0]  buf_q, buf_d, buf_wr;
  logic [WORD_AW-1:0] buf_word_q, buf_word_d;
  logic               buf_vld_q, buf_vld_d;

  // Result register
  logic               out_valid_q, out_valid_d;
  logic [KIND_W-1:0]  kind_q;
  logic [BLK_W-1:0]   ovl_q, endb_q;
  logic               last_q;
  logic               out_free;

  logic [USED_W-1:0]  ins_lim;
  logic [USED_W-1:0]  cur_nxt;

  // Addressing of the current block
  assign cur_word = cur_q[ENT_W +: WORD_AW];
  assign ent_bit  = {cur_q[ENT_W-1:0], 1'b0};
  assign cnt_eff  = (block_count_i == '0) ? CNT_W'(1) : block_count_i;

  // Buffer update
  always_comb begin
    buf_wr = buf_q;
    buf_wr[ent_bit +: 2] = cmd_i.wr_st;
    buf_d      = buf_q;
    buf_word_d = buf_word_q;
    buf_vld_d  = buf_vld_q;
    if (cmd_i.fill) begin
      buf_d      = rdata_q;
      buf_word_d = cur_word;
      buf_vld_d  = 1'b1;
    end else if (cmd_i.wr_en) begin
      buf_d = buf_wr;
    end
  end

  // Memory port selection
  assign mem_we    = cmd_i.clr_en | cmd_i.wr_en;
  assign mem_waddr = cmd_i.clr_en ? clr_cnt_q : buf_word_q;
  assign mem_wdata = cmd_i.clr_en ? '0 : buf_wr;
  assign clr_cnt_d = clr_cnt_q + WORD_AW'(1);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[cur_word];
  end

  // Cursor and end block
  always_comb begin
    unique case (cmd_i.cur_op)
      CUR_HOLD: cur_d = cur_q;
      CUR_B0:   cur_d = b0_q;
      CUR_INC:  cur_d = cur_q + BLK_W'(1);
      CUR_DEC:  cur_d = cur_q - BLK_W'(1);
      default:  cur_d = cur_q;
    endcase
    unique case (cmd_i.end_op)
      END_HOLD: end_d = end_q;
      END_INS:  end_d = b0_q + BLK_W'(cnt_q) - BLK_W'(1);
      END_CUR:  end_d = cur_q;
      default:  end_d = end_q;
    endcase
  end

  // Result register handshake
  assign out_free = !out_valid_q || out_ready_i;
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit_en) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      buf_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_en) begin
        clr_cnt_q <= clr_cnt_d;
      end
      buf_vld_q   <= buf_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      req_rm_q <= req_type_i;
      b0_q     <= start_block_i;
      cnt_q    <= cnt_eff;
    end
    cur_q      <= cur_d;
    end_q      <= end_d;
    buf_q      <= buf_d;
    buf_word_q <= buf_word_d;
    if (cmd_i.emit_en) begin
      kind_q <= cmd_i.emit_kind;
      ovl_q  <= (cmd_i.emit_kind == RES_OVERLAP) ? cur_q : '0;
      endb_q <= (cmd_i.emit_kind == RES_DONE) ? end_q : '0;
      last_q <= (cmd_i.emit_kind != RES_OVERLAP);
    end
  end

  // Status
  assign ins_lim = {1'b0, b0_q} + USED_W'(cnt_q);
  assign cur_nxt = {1'b0, cur_q} + USED_W'(1);

  always_comb begin
    sts_o.clr_last      = (clr_cnt_q == WORD_AW'(MAP_WORDS - 1));
    sts_o.hit           = buf_vld_q && (buf_word_q == cur_word);
    sts_o.ent_st        = blk_st_e'(buf_q[ent_bit +: 2]);
    sts_o.range_err     = req_rm_q ? ({1'b0, b0_q} >= used_i) : (ins_lim > used_i);
    sts_o.is_remove     = req_rm_q;
    sts_o.cur_zero      = (cur_q == '0);
    sts_o.cur_at_end    = (cur_q == end_q);
    sts_o.cur_last_used = (cur_nxt >= used_i);
    sts_o.out_free      = out_free;
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = kind_q;
  assign overlap_start_o = ovl_q;
  assign end_block_o     = endb_q;
  assign last_o          = last_q;

endmodule

@@ rtl/core/tbsm_ctrl.sv @@
// Controller: sequences clearing, range checks, forward marking, backward search and removal.
`timescale 1ns / 1ps
module tbsm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tbsm_pkg::sts_t sts_i,
  output tbsm_pkg::cmd_t cmd_o
);
  import tbsm_pkg::*;

  ctrl_state_e state_q, state_d;
  ctrl_state_e ret_q, ret_d;
  logic        st_start;
  logic        st_in;
  logic        needs_word;

  assign st_start = (sts_i.ent_st == BLK_START);
  assign st_in    = (sts_i.ent_st == BLK_IN);

  // States that work on the entry under the cursor
  assign needs_word = (state_q == S_INS_FIRST) || (state_q == S_SRCH) ||
                      (state_q == S_INS_MARK) || (state_q == S_INS_REST) ||
                      (state_q == S_RM_FIRST) || (state_q == S_RM_WALK);

  // Next state
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    if (needs_word && !sts_i.hit) begin
      ret_d   = state_q;
      state_d = S_FETCH;
    end else begin
      unique case (state_q)
        S_CLEAR: if (sts_i.clr_last) state_d = S_IDLE;
        S_IDLE:  if (in_valid_i) state_d = S_CHECK;
        S_CHECK: begin
          if (sts_i.range_err) state_d = S_ERR;
          else if (sts_i.is_remove) state_d = S_RM_FIRST;
          else state_d = S_INS_FIRST;
        end
        S_FETCH: state_d = S_FILL;
        S_FILL:  state_d = ret_q;
        S_INS_FIRST: begin
          if (st_start) begin
            if (sts_i.out_free) state_d = S_INS_MARK;
          end else if (st_in && !sts_i.cur_zero) begin
            state_d = S_SRCH;
          end else begin
            state_d = S_INS_MARK;
          end
        end
        S_SRCH: begin
          if (st_start) begin
            if (sts_i.out_free) state_d = S_INS_MARK;
          end else if (sts_i.cur_zero) begin
            state_d = S_INS_MARK;
          end
        end
        S_INS_MARK: begin
          state_d = sts_i.cur_at_end ? S_DONE : S_INS_REST;
        end
        S_INS_REST: begin
          if ((!st_start || sts_i.out_free) && sts_i.cur_at_end) state_d = S_DONE;
        end
        S_RM_FIRST: begin
          if (!st_start) state_d = S_ERR;
          else if (sts_i.cur_last_used) state_d = S_DONE;
          else state_d = S_RM_WALK;
        end
        S_RM_WALK: begin
          if (!st_in || sts_i.cur_last_used) state_d = S_DONE;
        end
        S_DONE, S_ERR: if (sts_i.out_free) state_d = S_IDLE;
        default: state_d = S_IDLE;
      endcase
    end
  end

  // Outputs
  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    cmd_o.cur_op    = CUR_HOLD;
    cmd_o.end_op    = END_HOLD;
    cmd_o.wr_st     = BLK_EMPTY;
    cmd_o.emit_kind = RES_OVERLAP;
    unique case (state_q)
      S_CLEAR: cmd_o.clr_en = 1'b1;
      S_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.req_load = in_valid_i;
      end
      S_CHECK: begin
        cmd_o.cur_op = CUR_B0;
        cmd_o.end_op = sts_i.is_remove ? END_HOLD : END_INS;
      end
      S_FETCH: ;
      S_FILL:  cmd_o.fill = 1'b1;
      S_INS_FIRST: if (sts_i.hit) begin
        if (st_start) begin
          cmd_o.emit_en = sts_i.out_free;
        end else if (st_in && !sts_i.cur_zero) begin
          cmd_o.cur_op = CUR_DEC;
        end
      end
      S_SRCH: if (sts_i.hit) begin
        if (st_start) begin
          if (sts_i.out_free) begin
            cmd_o.emit_en = 1'b1;
            cmd_o.cur_op  = CUR_B0;
          end
        end else if (sts_i.cur_zero) begin
          cmd_o.cur_op = CUR_B0;
        end else begin
          cmd_o.cur_op = CUR_DEC;
        end
      end
      S_INS_MARK: if (sts_i.hit) begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wr_st = BLK_START;
        if (!sts_i.cur_at_end) cmd_o.cur_op = CUR_INC;
      end
      S_INS_REST: if (sts_i.hit && (!st_start || sts_i.out_free)) begin
        cmd_o.emit_en = st_start;
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_st   = BLK_IN;
        if (!sts_i.cur_at_end) cmd_o.cur_op = CUR_INC;
      end
      S_RM_FIRST: if (sts_i.hit && st_start) begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.end_op = END_CUR;
        if (!sts_i.cur_last_used) cmd_o.cur_op = CUR_INC;
      end
      S_RM_WALK: if (sts_i.hit && st_in) begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.end_op = END_CUR;
        if (!sts_i.cur_last_used) cmd_o.cur_op = CUR_INC;
      end
      S_DONE: begin
        cmd_o.emit_en   = sts_i.out_free;
        cmd_o.emit_kind = RES_DONE;
      end
      S_ERR: begin
        cmd_o.emit_en   = sts_i.out_free;
        cmd_o.emit_kind = RES_ERROR;
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ret_q   <= S_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_en |-> sts_i.out_free)
    else $error("result emitted while result register is occupied");

  a_wr_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_en |-> sts_i.hit)
    else $error("map write without the cursor word in the buffer");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item taken before the first was finished");

  a_fill_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL) |-> $past(state_q == S_FETCH))
    else $error("buffer fill without a preceding fetch");
`endif

endmodule

@@ rtl/core/two_bit_segment_map.sv @@
// Top level of the two-bit segment map: configuration port, controller and datapath.
//
// Keeps a 2-bit state (empty, start, in, err) for every block in a 2048 x 64-bit map
// and handles one insert or remove request at a time. After reset a clearing pass
// zeroes the map word by word; no item is taken until it ends. An item is then taken
// and range checked. The walk looks at the first block of an insert, steps over blocks
// in the backward search for an owning start block, and marks or clears blocks one at
// a time; a remove also looks at the block past its end. The final result is then
// handed over. Each time the walk reaches a map word that is not in the word buffer,
// it detects the miss, then does the registered map read and the buffer fill. A result
// item that finds the output register still full holds the walk until the receiver
// takes the waiting one. Results are held in an output register, so a new item is
// taken while the final result of the previous one waits.
`timescale 1ns / 1ps
module two_bit_segment_map (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  tbsm_req_if.sink                        req_chan,
  tbsm_res_if.source                      res_chan,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tbsm_pkg::APB_AW-1:0]     paddr,
  input  logic [tbsm_pkg::APB_DW-1:0]     pwdata,
  output logic [tbsm_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);
  import tbsm_pkg::*;

  logic [CFG_W-1:0]     map_words_q;
  logic [CFG_W-1:0]     words_clamped;
  logic [USED_W-1:0]    used_blocks;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  cmd_t                 cmd;
  sts_t                 sts;

  // Configuration register access
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && (reg_idx == REG_MAP_WORDS);
  assign prdata  = (reg_idx == REG_MAP_WORDS) ? APB_DW'(map_words_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_words_q <= CFG_RESET;
    end else if (cfg_wr) begin
      map_words_q <= pwdata[CFG_W-1:0];
    end
  end

  // Blocks in use: word count clamped to the map size
  assign words_clamped = (map_words_q > CFG_W'(MAP_WORDS)) ? CFG_W'(MAP_WORDS) : map_words_q;
  assign used_blocks   = USED_W'(words_clamped) << ENT_W;

  tbsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_chan.valid),
    .in_ready_o (req_chan.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tbsm_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .used_i          (used_blocks),
    .req_type_i      (req_chan.req_type),
    .start_block_i   (req_chan.start_block),
    .block_count_i   (req_chan.block_count),
    .out_ready_i     (res_chan.ready),
    .out_valid_o     (res_chan.valid),
    .result_kind_o   (res_chan.result_kind),
    .overlap_start_o (res_chan.overlap_start),
    .end_block_o     (res_chan.end_block),
    .last_o          (res_chan.last)
  );

endmodule
